@@ src/wlan_mac_header_parser_assert.svh @@
// Assertion macros shared by the checker of the 802.11 MAC header parser.
`ifndef WLAN_MAC_HEADER_PARSER_ASSERT_SVH
`define WLAN_MAC_HEADER_PARSER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define WMHP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high.
`define WMHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/wmhp_pkg.sv @@
// Types, constants and lookup functions of the 802.11 MAC header parser.
package wmhp_pkg;

  typedef logic [47:0] mac_t;
  typedef logic [5:0]  pos_t;
  typedef logic [6:0]  len_t;

  typedef enum logic [1:0] {
    FT_MGMT = 2'd0,
    FT_CTRL = 2'd1,
    FT_DATA = 2'd2,
    FT_EXT  = 2'd3
  } frame_type_t;

  // Byte positions within the header
  localparam pos_t POS_CTL_LO   = 6'd0;
  localparam pos_t POS_CTL_HI   = 6'd1;
  localparam pos_t POS_ADDR1    = 6'd4;
  localparam pos_t POS_ADDR2    = 6'd10;
  localparam pos_t POS_ADDR3    = 6'd16;
  localparam pos_t POS_SEQ_LO   = 6'd22;
  localparam pos_t POS_SEQ_HI   = 6'd23;
  localparam pos_t POS_ADDR4    = 6'd24;
  localparam pos_t POS_ADDR4_END = 6'd30;
  localparam pos_t COUNT_MAX    = 6'd63;

  // Header lengths
  localparam pos_t HDR_CTRL_SHORT = 6'd10;
  localparam pos_t HDR_CTRL_LONG  = 6'd16;
  localparam pos_t HDR_BASE       = 6'd24;
  localparam pos_t HDR_4ADDR      = 6'd30;
  localparam pos_t HDR_QOS_ADD    = 6'd2;
  localparam pos_t HDR_HTC_ADD    = 6'd4;
  localparam pos_t SNAP_LEN       = 6'd8;
  localparam len_t LEN_MIN        = 7'd2;

  // Subtype codes
  localparam logic [3:0] SUB_ASSOC_REQ    = 4'd0;
  localparam logic [3:0] SUB_ASSOC_RESP   = 4'd1;
  localparam logic [3:0] SUB_REASSOC_REQ  = 4'd2;
  localparam logic [3:0] SUB_REASSOC_RESP = 4'd3;
  localparam logic [3:0] SUB_PROBE_REQ    = 4'd4;
  localparam logic [3:0] SUB_PROBE_RESP   = 4'd5;
  localparam logic [3:0] SUB_BEACON       = 4'd8;
  localparam logic [3:0] SUB_CTS          = 4'd12;
  localparam logic [3:0] SUB_ACK          = 4'd13;

  // DS field codes, bit 0 to-DS, bit 1 from-DS
  localparam logic [1:0] DS_NONE = 2'd0;
  localparam logic [1:0] DS_TO   = 2'd1;
  localparam logic [1:0] DS_FROM = 2'd2;
  localparam logic [1:0] DS_WDS  = 2'd3;

  localparam logic [1:0] PROTO_VERSION = 2'd0;

  // Frame state seen by the decoder, already updated with the final byte
  typedef struct packed {
    logic [15:0]     ctl;
    logic [15:0]     seq;
    logic [3:0][47:0] addr;
    logic            snap;
    len_t            len;
  } frame_state_t;

  typedef struct packed {
    logic        ok;
    logic [1:0]  frame_type;
    logic [3:0]  subtype;
    logic [4:0]  flags;
    logic [5:0]  header_length;
    logic [5:0]  ie_offset;
    logic [11:0] sequence_res;
    mac_t        receiver;
    mac_t        transmitter;
    mac_t        destination;
    mac_t        source_addr;
    mac_t        bssid;
  } result_t;

  // LLC/SNAP header carrying EtherType 888E
  function automatic logic [7:0] snap_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'haa;
      3'd1:    b = 8'haa;
      3'd2:    b = 8'h03;
      3'd6:    b = 8'h88;
      3'd7:    b = 8'h8e;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic pos_t data_hdr_len(input logic [15:0] ctl);
    pos_t hl;
    hl = (ctl[9:8] == DS_WDS) ? HDR_4ADDR : HDR_BASE;
    if (ctl[7]) begin
      hl = hl + HDR_QOS_ADD;
      if (ctl[15]) begin
        hl = hl + HDR_HTC_ADD;
      end
    end
    return hl;
  endfunction

  function automatic pos_t ie_start(input logic [3:0] sub);
    pos_t ie;
    case (sub)
      SUB_ASSOC_REQ:    ie = 6'd28;
      SUB_ASSOC_RESP:   ie = 6'd30;
      SUB_REASSOC_REQ:  ie = 6'd34;
      SUB_REASSOC_RESP: ie = 6'd30;
      SUB_PROBE_REQ:    ie = 6'd24;
      SUB_PROBE_RESP:   ie = 6'd36;
      SUB_BEACON:       ie = 6'd36;
      default:          ie = 6'd0;
    endcase
    return ie;
  endfunction

endpackage

@@ src/wmhp_decode.sv @@
// Header decode: length checks, address routing and result masking.
module wmhp_decode import wmhp_pkg::*; (
  input  frame_state_t fs,
  output result_t      res
);

  logic [1:0] ftype;
  logic [3:0] sub;
  logic [1:0] ds;
  pos_t       hl;
  pos_t       ie;
  result_t    raw;

  assign ftype = fs.ctl[3:2];
  assign sub   = fs.ctl[7:4];
  assign ds    = fs.ctl[9:8];

  always_comb begin
    raw = '0;
    hl  = '0;
    ie  = '0;
    raw.frame_type = ftype;
    raw.subtype    = sub;
    raw.flags      = {1'b0, fs.ctl[14], fs.ctl[11], fs.ctl[9], fs.ctl[8]};
    if (fs.len >= LEN_MIN && fs.ctl[1:0] == PROTO_VERSION) begin
      if (ftype == FT_CTRL) begin
        if (fs.len >= 7'(HDR_CTRL_SHORT)) begin
          hl = (sub == SUB_CTS || sub == SUB_ACK) ? HDR_CTRL_SHORT : HDR_CTRL_LONG;
          if (fs.len >= 7'(hl)) begin
            raw.ok       = 1'b1;
            raw.receiver = fs.addr[0];
            if (hl == HDR_CTRL_LONG) begin
              raw.transmitter = fs.addr[1];
            end
          end
        end
      end else if (fs.len >= 7'(HDR_BASE)) begin
        raw.receiver     = fs.addr[0];
        raw.transmitter  = fs.addr[1];
        raw.sequence_res = fs.seq[15:4];
        hl = HDR_BASE;
        if (ftype == FT_MGMT) begin
          raw.destination = fs.addr[0];
          raw.source_addr = fs.addr[1];
          raw.bssid       = fs.addr[2];
          ie     = ie_start(sub);
          raw.ok = (7'(ie) <= fs.len);
        end else if (ftype == FT_EXT) begin
          raw.ok = 1'b1;
        end else begin
          raw.ok = 1'b1;
          case (ds)
            DS_WDS: begin
              if (fs.len < 7'(HDR_4ADDR)) begin
                raw.ok = 1'b0;
              end
              raw.destination = fs.addr[2];
              raw.source_addr = fs.addr[3];
            end
            DS_TO: begin
              raw.bssid       = fs.addr[0];
              raw.source_addr = fs.addr[1];
              raw.destination = fs.addr[2];
            end
            DS_FROM: begin
              raw.destination = fs.addr[0];
              raw.bssid       = fs.addr[1];
              raw.source_addr = fs.addr[2];
            end
            default: begin
              raw.destination = fs.addr[0];
              raw.source_addr = fs.addr[1];
              raw.bssid       = fs.addr[2];
            end
          endcase
          hl = data_hdr_len(fs.ctl);
          if (7'(hl) > fs.len) begin
            raw.ok = 1'b0;
          end
          if (raw.ok && !fs.ctl[14] && fs.len >= 7'(hl) + 7'(SNAP_LEN) && fs.snap) begin
            raw.flags[4] = 1'b1;
          end
        end
      end
    end
    raw.header_length = hl;
    raw.ie_offset     = ie;
  end

  // zero every field of a failed frame
  assign res = raw.ok ? raw : '0;

endmodule

@@ src/wlan_mac_header_parser.sv @@
// Top level of the streaming 802.11 MAC header parser.
//
// The parser takes a received 802.11 frame one byte per transfer, first byte
// first, with last_byte marking the final byte, and returns exactly one result
// transfer per frame. It captures the little-endian frame control word,
// addresses 1 to 4 and the sequence control field as the bytes go by, and at
// the final byte decodes type, subtype and the DS, retry and protected bits,
// routes the addresses to destination, source and BSSID, works out the header
// length and the management IE offset, and runs every length check. For an
// unprotected data frame it also reports (flags bit 4) whether the eight bytes
// right after the header are the LLC/SNAP EAPOL marker. A failed frame gives
// ok low and every other field zero. Address bit 47..40 holds the first byte
// seen on the air. The byte counter stops at 63; bytes beyond the header only
// feed the EAPOL check. Rate: one byte is accepted every cycle; the result of
// a frame is in the result register in the cycle after its final byte and the
// next frame can start in that same cycle. The single result register sets
// the only wait: a final byte is held (byte_stall) while the previous
// frame's result is still stalled at the output; other bytes keep flowing.
module wlan_mac_header_parser import wmhp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        ok,
  output logic [1:0]  frame_type,
  output logic [3:0]  subtype,
  output logic [4:0]  flags,
  output logic [5:0]  header_length,
  output logic [5:0]  ie_offset,
  output logic [11:0] sequence_res,
  output logic [47:0] receiver,
  output logic [47:0] transmitter,
  output logic [47:0] destination,
  output logic [47:0] source_addr,
  output logic [47:0] bssid
);

  // frame capture state
  pos_t             byte_count;
  logic [15:0]      ctl;
  logic [15:0]      seq;
  logic [3:0][47:0] addr;
  logic             snap;

  logic [15:0]      ctl_next;
  logic [15:0]      seq_next;
  logic [3:0][47:0] addr_next;
  logic             snap_next;

  pos_t             dh;
  pos_t             snap_pos;
  logic             accept;
  logic             result_free;

  frame_state_t     fs;
  result_t          dec;
  result_t          result;

  // The result register is free when empty or being drained this cycle.
  assign result_free = !result_valid || !result_stall;
  // Hold only a final byte that has nowhere to put its result.
  assign byte_stall  = last_byte && !result_free;
  assign accept      = byte_valid && !byte_stall;

  // Capture the byte into the field its position selects.
  always_comb begin
    ctl_next  = ctl;
    seq_next  = seq;
    addr_next = addr;
    if (byte_count == POS_CTL_LO) begin
      ctl_next[7:0] = data_byte;
    end else if (byte_count == POS_CTL_HI) begin
      ctl_next[15:8] = data_byte;
    end else if (byte_count >= POS_ADDR1 && byte_count < POS_ADDR2) begin
      addr_next[0] = {addr[0][39:0], data_byte};
    end else if (byte_count >= POS_ADDR2 && byte_count < POS_ADDR3) begin
      addr_next[1] = {addr[1][39:0], data_byte};
    end else if (byte_count >= POS_ADDR3 && byte_count < POS_SEQ_LO) begin
      addr_next[2] = {addr[2][39:0], data_byte};
    end else if (byte_count == POS_SEQ_LO) begin
      seq_next[7:0] = data_byte;
    end else if (byte_count == POS_SEQ_HI) begin
      seq_next[15:8] = data_byte;
    end else if (byte_count >= POS_ADDR4 && byte_count < POS_ADDR4_END) begin
      addr_next[3] = {addr[3][39:0], data_byte};
    end
  end

  // EAPOL check: compare the eight bytes after the data header with the
  // LLC/SNAP marker. The frame control word is complete by then, and the
  // header is at least 24 bytes, so the partial word seen earlier never hits.
  assign dh       = data_hdr_len(ctl);
  assign snap_pos = byte_count - dh;

  always_comb begin
    snap_next = snap;
    if (byte_count >= POS_SEQ_LO - POS_SEQ_LO + 6'd2 && byte_count >= dh &&
        snap_pos < SNAP_LEN && data_byte != snap_byte(snap_pos[2:0])) begin
      snap_next = 1'b0;
    end
  end

  // The decoder sees the state with the final byte already folded in.
  assign fs.ctl  = ctl_next;
  assign fs.seq  = seq_next;
  assign fs.addr = addr_next;
  assign fs.snap = snap_next;
  assign fs.len  = 7'(byte_count) + 7'd1;

  wmhp_decode u_decode (
    .fs  (fs),
    .res (dec)
  );

  // Advance the capture state; return to the start after a final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      ctl        <= '0;
      seq        <= '0;
      addr       <= '0;
      snap       <= 1'b1;
    end else if (accept) begin
      if (last_byte) begin
        byte_count <= '0;
        ctl        <= '0;
        seq        <= '0;
        addr       <= '0;
        snap       <= 1'b1;
      end else begin
        ctl  <= ctl_next;
        seq  <= seq_next;
        addr <= addr_next;
        snap <= snap_next;
        if (byte_count != COUNT_MAX) begin
          byte_count <= byte_count + 6'd1;
        end
      end
    end
  end

  // Result register: load at a final byte, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept && last_byte) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_byte) begin
      result <= dec;
    end
  end

  assign ok            = result.ok;
  assign frame_type    = result.frame_type;
  assign subtype       = result.subtype;
  assign flags         = result.flags;
  assign header_length = result.header_length;
  assign ie_offset     = result.ie_offset;
  assign sequence_res  = result.sequence_res;
  assign receiver      = result.receiver;
  assign transmitter   = result.transmitter;
  assign destination   = result.destination;
  assign source_addr   = result.source_addr;
  assign bssid         = result.bssid;

endmodule

@@ src/wmhp_checker.sv @@
// Port-level checker of the 802.11 MAC header parser, bound to the top level.
`include "wlan_mac_header_parser_assert.svh"

module wmhp_checker import wmhp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        byte_valid,
  input logic        byte_stall,
  input logic        last_byte,
  input logic        result_valid,
  input logic        result_stall,
  input logic        ok,
  input logic [1:0]  frame_type,
  input logic [3:0]  subtype,
  input logic [4:0]  flags,
  input logic [5:0]  header_length,
  input logic [5:0]  ie_offset,
  input logic [11:0] sequence_res,
  input logic [47:0] receiver,
  input logic [47:0] transmitter,
  input logic [47:0] destination,
  input logic [47:0] source_addr,
  input logic [47:0] bssid
);

  // every field but ok cleared
  logic fields_zero;

  assign fields_zero = frame_type == 2'd0 && subtype == 4'd0 && flags == 5'd0 &&
                       header_length == 6'd0 && ie_offset == 6'd0 &&
                       sequence_res == 12'd0 && receiver == 48'd0 &&
                       transmitter == 48'd0 && destination == 48'd0 &&
                       source_addr == 48'd0 && bssid == 48'd0;

  // hold a stalled result
  `WMHP_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(ok) && $stable(receiver) && $stable(header_length), "stalled result changed")

  // a new result follows only a transferred final byte
  `WMHP_ASSERT_IMPLY(a_result_cause, $rose(result_valid), $past(byte_valid && !byte_stall && last_byte), "result without a final byte")

  // drop every field of a failed frame
  `WMHP_ASSERT_IMPLY(a_fail_zero, result_valid && !ok, fields_zero, "failed frame carries data")

  // control frames are 10 or 16 bytes of header
  `WMHP_ASSERT_IMPLY(a_ctrl_len, result_valid && ok && frame_type == FT_CTRL, header_length == HDR_CTRL_SHORT || header_length == HDR_CTRL_LONG, "bad control header length")

  // EAPOL only on good unprotected data frames
  `WMHP_ASSERT_IMPLY(a_eapol_data, result_valid && flags[4], ok && frame_type == FT_DATA && !flags[3], "EAPOL flag on wrong frame")

endmodule

bind wlan_mac_header_parser wmhp_checker u_checker (.*);

@@ bench/wlan_mac_header_parser_test.sv @@
// Self-checking testbench for the streaming 802.11 MAC header parser.
`timescale 1ns / 100ps

module wlan_mac_header_parser_test;
  import wmhp_pkg::*;

  // Random traffic stops once this many bytes have been sent in total.
  localparam int ITEM_TARGET  = 1450;
  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the receiver hold-off below plus a few
  // random gaps, so this is several times that.
  localparam int STUCK_LIMIT  = 2000;
  localparam int HOLD_OFF     = 150;
  // Extra cycles to let the pipe settle after the last result.
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;
  localparam int EAPOL_BIT    = 4;
  localparam logic [1:0] BAD_VERSION = 2'd3;

  // Snap kinds for generated frames
  localparam int SNAP_NONE    = 0;
  localparam int SNAP_INTACT  = 1;
  localparam int SNAP_BROKEN  = 2;

  // LLC/SNAP header that carries EtherType 888E (EAPOL)
  localparam logic [7:0] EAPOL_SNAP [8] = '{8'haa, 8'haa, 8'h03, 8'h00,
                                            8'h00, 8'h00, 8'h88, 8'h8e};

  logic        clk = 1'b0;
  logic        rst;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  data_byte;
  logic        last_byte;
  logic        result_valid;
  logic        result_stall;
  logic        ok;
  logic [1:0]  frame_type;
  logic [3:0]  subtype;
  logic [4:0]  flags;
  logic [5:0]  header_length;
  logic [5:0]  ie_offset;
  logic [11:0] sequence_res;
  logic [47:0] receiver;
  logic [47:0] transmitter;
  logic [47:0] destination;
  logic [47:0] source_addr;
  logic [47:0] bssid;

  wlan_mac_header_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (byte_valid),
    .byte_stall    (byte_stall),
    .data_byte     (data_byte),
    .last_byte     (last_byte),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .ok            (ok),
    .frame_type    (frame_type),
    .subtype       (subtype),
    .flags         (flags),
    .header_length (header_length),
    .ie_offset     (ie_offset),
    .sequence_res  (sequence_res),
    .receiver      (receiver),
    .transmitter   (transmitter),
    .destination   (destination),
    .source_addr   (source_addr),
    .bssid         (bssid)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Decoded headers waiting to come out of the block, oldest first
  result_t pending_headers [$];

  int fail_count  = 0;
  int bytes_sent  = 0;
  int stuck_count = 0;

  // Idle controls shared between the stimulus and the result drain
  bit tx_gaps     = 1'b1;
  bit rx_gaps     = 1'b1;
  int hold_cycles = 0;

  // Shadow copy of the frame being received
  logic [5:0]  rx_pos;
  logic [15:0] rx_fc;
  logic [15:0] rx_sc;
  logic [47:0] rx_addr [4];
  logic        rx_snap_ok;

  // ---------------------------------------------------------------------------
  // Header decoding
  // ---------------------------------------------------------------------------

  // Data header length: 24 or 30 with four addresses, +2 for QoS, +4 more for
  // the order bit on a QoS frame.
  function automatic int wire_hdr_len(input logic [15:0] fc);
    int h;
    h = (fc[9:8] == DS_WDS) ? int'(HDR_4ADDR) : int'(HDR_BASE);
    if (fc[7]) begin
      h = h + int'(HDR_QOS_ADD);
      if (fc[15]) begin
        h = h + int'(HDR_HTC_ADD);
      end
    end
    return h;
  endfunction

  // Where the information elements start in each management subtype
  function automatic int mgmt_ie(input logic [3:0] sub);
    int ie;
    case (sub)
      SUB_ASSOC_REQ:    ie = 28;
      SUB_ASSOC_RESP:   ie = 30;
      SUB_REASSOC_REQ:  ie = 34;
      SUB_REASSOC_RESP: ie = 30;
      SUB_PROBE_REQ:    ie = 24;
      SUB_PROBE_RESP:   ie = 36;
      SUB_BEACON:       ie = 36;
      default:          ie = 0;
    endcase
    return ie;
  endfunction

  function automatic void clear_shadow();
    rx_pos     = '0;
    rx_fc      = '0;
    rx_sc      = '0;
    rx_addr    = '{default: '0};
    rx_snap_ok = 1'b1;
  endfunction

  // Fold one accepted byte into the shadow frame; on the final byte decode
  // the header, queue the expected result and start over.
  task automatic parse_byte(input logic [7:0] d, input logic fin);
    int          idx;
    int          len;
    int          hl;
    int          ie;
    int          slot;
    logic [3:0]  sub;
    logic [4:0]  fl;
    logic        good;
    frame_type_t ft;
    result_t     r;
    idx = int'(rx_pos);
    if (idx == POS_CTL_LO) begin
      rx_fc[7:0] = d;
    end else if (idx == POS_CTL_HI) begin
      rx_fc[15:8] = d;
    end else if (idx >= POS_ADDR1 && idx < POS_SEQ_LO) begin
      slot = (idx - int'(POS_ADDR1)) / 6;
      rx_addr[slot] = {rx_addr[slot][39:0], d};
    end else if (idx == POS_SEQ_LO) begin
      rx_sc[7:0] = d;
    end else if (idx == POS_SEQ_HI) begin
      rx_sc[15:8] = d;
    end else if (idx >= POS_ADDR4 && idx < POS_ADDR4_END) begin
      rx_addr[3] = {rx_addr[3][39:0], d};
    end

    // Any byte in the eight slots after the data header that misses the
    // SNAP pattern kills the EAPOL match for this frame.
    if (idx >= int'(POS_ADDR1) - 2) begin
      hl = wire_hdr_len(rx_fc);
      if (idx >= hl && idx < hl + 8 && d != EAPOL_SNAP[idx - hl]) begin
        rx_snap_ok = 1'b0;
      end
    end

    if (!fin) begin
      // Saturate: a long frame parks the position at the top.
      if (rx_pos != COUNT_MAX) begin
        rx_pos = rx_pos + 1'b1;
      end
    end else begin
      len  = idx + 1;
      ft   = frame_type_t'(rx_fc[3:2]);
      sub  = rx_fc[7:4];
      fl   = {1'b0, rx_fc[14], rx_fc[11], rx_fc[9], rx_fc[8]};
      hl   = 0;
      ie   = 0;
      good = 1'b0;
      r    = '0;
      if (len >= LEN_MIN && rx_fc[1:0] == PROTO_VERSION) begin
        if (ft == FT_CTRL) begin
          // CTS and ACK carry only the receiver address.
          if (len >= HDR_CTRL_SHORT) begin
            hl = (sub == SUB_CTS || sub == SUB_ACK) ? int'(HDR_CTRL_SHORT)
                                                    : int'(HDR_CTRL_LONG);
            if (len >= hl) begin
              good = 1'b1;
              r.receiver = rx_addr[0];
              if (hl == HDR_CTRL_LONG) begin
                r.transmitter = rx_addr[1];
              end
            end
          end
        end else if (len >= HDR_BASE) begin
          r.receiver     = rx_addr[0];
          r.transmitter  = rx_addr[1];
          r.sequence_res = rx_sc[15:4];
          hl = int'(HDR_BASE);
          if (ft == FT_MGMT) begin
            r.destination = rx_addr[0];
            r.source_addr = rx_addr[1];
            r.bssid       = rx_addr[2];
            ie   = mgmt_ie(sub);
            good = (ie <= len);
          end else if (ft == FT_EXT) begin
            // Extension frames pass with nothing routed.
            good = 1'b1;
          end else begin
            good = 1'b1;
            case (rx_fc[9:8])
              DS_WDS: begin
                good = (len >= HDR_4ADDR);
                r.destination = rx_addr[2];
                r.source_addr = rx_addr[3];
              end
              DS_TO: begin
                r.bssid       = rx_addr[0];
                r.source_addr = rx_addr[1];
                r.destination = rx_addr[2];
              end
              DS_FROM: begin
                r.destination = rx_addr[0];
                r.bssid       = rx_addr[1];
                r.source_addr = rx_addr[2];
              end
              default: begin
                r.destination = rx_addr[0];
                r.source_addr = rx_addr[1];
                r.bssid       = rx_addr[2];
              end
            endcase
            hl = wire_hdr_len(rx_fc);
            if (hl > len) begin
              good = 1'b0;
            end
            // EAPOL only counts on an unprotected frame with the full marker.
            if (good && !rx_fc[14] && len - hl >= 8 && rx_snap_ok) begin
              fl[EAPOL_BIT] = 1'b1;
            end
          end
        end
      end
      if (good) begin
        r.ok            = 1'b1;
        r.frame_type    = rx_fc[3:2];
        r.subtype       = sub;
        r.flags         = fl;
        r.header_length = hl[5:0];
        r.ie_offset     = ie[5:0];
      end else begin
        // A failed frame reports nothing but ok low.
        r = '0;
      end
      pending_headers.push_back(r);
      clear_shadow();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Byte channel
  // ---------------------------------------------------------------------------

  // Offer one byte after a random gap and hold it until the block takes it.
  // With no gap, valid simply stays high and only the payload moves on.
  task automatic send_byte(input logic [7:0] d, input logic fin);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    data_byte  <= d;
    last_byte  <= fin;
    do @(posedge clk); while (byte_stall);
    bytes_sent++;
    parse_byte(d, fin);
  endtask

  // Build and send one frame. The nominal length is the header the frame
  // type needs (or the IE start for management), plus eight SNAP bytes when
  // asked, plus extra; a negative extra truncates the frame.
  task automatic send_frame(input frame_type_t ft, input logic [3:0] sub,
                            input logic [1:0] ds, input logic prot,
                            input logic order, input logic [1:0] ver,
                            input int snap_kind, input int extra);
    logic [15:0] fc;
    logic [3:0]  misc;
    logic [7:0]  rb;
    logic [7:0]  octets [$];
    int          h;
    int          nominal;
    int          flen;
    int          fill;
    int          k;
    misc = 4'($urandom_range(0, 15));
    fc   = {order, prot, misc, ds, sub, ft, ver};
    h    = wire_hdr_len(fc);
    case (ft)
      FT_CTRL: nominal = (sub == SUB_CTS || sub == SUB_ACK) ? int'(HDR_CTRL_SHORT)
                                                            : int'(HDR_CTRL_LONG);
      FT_MGMT: nominal = (mgmt_ie(sub) > HDR_BASE) ? mgmt_ie(sub) : int'(HDR_BASE);
      FT_DATA: nominal = h;
      default: nominal = int'(HDR_BASE);
    endcase
    flen = nominal + extra + ((snap_kind != SNAP_NONE) ? 8 : 0);
    if (flen < 1) begin
      flen = 1;
    end
    // Mostly random content, sometimes all zeros or all ones.
    fill = $urandom_range(0, 7);
    for (k = 0; k < flen; k++) begin
      rb = 8'($urandom_range(0, 255));
      octets.push_back((fill == 0) ? 8'h00 : (fill == 1) ? 8'hff : rb);
    end
    octets[0] = fc[7:0];
    if (flen > 1) begin
      octets[1] = fc[15:8];
    end
    if (snap_kind != SNAP_NONE) begin
      for (k = 0; k < 8; k++) begin
        if (h + k < flen) begin
          octets[h + k] = EAPOL_SNAP[k];
        end
      end
      // Spoil one marker byte.
      if (snap_kind == SNAP_BROKEN && h + 7 < flen) begin
        k  = $urandom_range(0, 7);
        rb = 8'($urandom_range(1, 255));
        octets[h + k] = octets[h + k] ^ rb;
      end
    end
    for (k = 0; k < flen; k++) begin
      send_byte(octets[k], k == flen - 1);
    end
  endtask

  // One frame of the given type with random fields. The protocol version is
  // now and then nonzero, and the length sometimes falls short of the header.
  task automatic send_random_frame(input frame_type_t ft, input int snap_kind);
    logic [3:0] sub;
    logic [1:0] ds;
    logic [1:0] ver;
    logic       prot;
    logic       order;
    int         extra;
    sub = 4'($urandom_range(0, 15));
    if (ft == FT_MGMT && $urandom_range(0, 3) != 0) begin
      // Favor the subtypes that carry IEs.
      sub = 4'($urandom_range(0, 6));
      if (sub == 4'd6) begin
        sub = SUB_BEACON;
      end
    end
    ds    = 2'($urandom_range(0, 3));
    prot  = ($urandom_range(0, 3) == 0);
    order = 1'($urandom_range(0, 1));
    ver   = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(1, 3)) : PROTO_VERSION;
    extra = $urandom_range(0, 12);
    extra = extra - 3;
    send_frame(ft, sub, ds, prot, order, ver, snap_kind, extra);
  endtask

  // ---------------------------------------------------------------------------
  // Result channel
  // ---------------------------------------------------------------------------

  // Drain results: before each one, stall for a random count of cycles, or
  // for the long hold-off when a test asks for it.
  initial begin : drain_results
    int wait_n;
    result_stall <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_cycles > 0) begin
        wait_n = hold_cycles;
      end else begin
        wait_n = rx_gaps ? $urandom_range(0, 8) : 0;
      end
      hold_cycles = 0;
      if (wait_n > 0) begin
        result_stall <= 1'b1;
        repeat (wait_n) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
    end
  end

  task automatic check_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_REPORTS) begin
        $display("mismatch on %s: expected %h, got %h", name, want, got);
      end
    end
  endtask

  // Compare every result transfer with the oldest decoded header.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_headers.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("result transfer with no frame outstanding");
        end
      end else begin
        want = pending_headers.pop_front();
        check_field("ok",            48'(want.ok),            48'(ok));
        check_field("frame_type",    48'(want.frame_type),    48'(frame_type));
        check_field("subtype",       48'(want.subtype),       48'(subtype));
        check_field("flags",         48'(want.flags),         48'(flags));
        check_field("header_length", 48'(want.header_length), 48'(header_length));
        check_field("ie_offset",     48'(want.ie_offset),     48'(ie_offset));
        check_field("sequence_res",  48'(want.sequence_res),  48'(sequence_res));
        check_field("receiver",      want.receiver,           receiver);
        check_field("transmitter",   want.transmitter,        transmitter);
        check_field("destination",   want.destination,        destination);
        check_field("source_addr",   want.source_addr,        source_addr);
        check_field("bssid",         want.bssid,              bssid);
      end
    end
  end

  // Count cycles with no transfer on either side; bail out if it hangs.
  always @(posedge clk) begin
    if (rst || (byte_valid && !byte_stall) || (result_valid && !result_stall)) begin
      stuck_count <= 0;
    end else begin
      stuck_count <= stuck_count + 1;
    end
    if (stuck_count >= STUCK_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-built frames: a lone byte, a two-byte frame, an ACK with all-ones
  // address, and the same ACK with a bad protocol version.
  task automatic test_short_frames();
    int k;
    send_byte(8'hff, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte({SUB_ACK, FT_CTRL, PROTO_VERSION}, 1'b0);
    for (k = 1; k < HDR_CTRL_SHORT; k++) begin
      send_byte(8'hff, k == HDR_CTRL_SHORT - 1);
    end
    send_byte({SUB_ACK, FT_CTRL, BAD_VERSION}, 1'b0);
    for (k = 1; k < HDR_CTRL_SHORT; k++) begin
      send_byte(8'hff, k == HDR_CTRL_SHORT - 1);
    end
  endtask

  task automatic test_control_frames();
    repeat (6) send_random_frame(FT_CTRL, SNAP_NONE);
  endtask

  task automatic test_management_frames();
    repeat (6) send_random_frame(FT_MGMT, SNAP_NONE);
  endtask

  // All four DS combinations, with QoS and order bits at random.
  task automatic test_data_routing();
    logic [1:0] ds;
    for (int k = 0; k < 8; k++) begin
      ds = k[1:0];
      send_frame(FT_DATA, 4'($urandom_range(0, 15)), ds, 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)), PROTO_VERSION, SNAP_NONE,
                 $urandom_range(0, 6));
    end
  endtask

  // Intact and spoiled SNAP markers right after the data header.
  task automatic test_eapol_detection();
    repeat (3) send_frame(FT_DATA, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                          1'b0, 1'($urandom_range(0, 1)), PROTO_VERSION, SNAP_INTACT,
                          $urandom_range(0, 3));
    send_frame(FT_DATA, 4'($urandom_range(0, 15)), DS_NONE, 1'b1, 1'b0,
               PROTO_VERSION, SNAP_INTACT, 0);
    send_random_frame(FT_DATA, SNAP_BROKEN);
  endtask

  task automatic test_extension_frames();
    repeat (3) send_random_frame(FT_EXT, SNAP_NONE);
  endtask

  // Long frames: a 70-byte beacon drives the byte counter to 63; the data frame may.
  task automatic test_long_frames();
    send_frame(FT_DATA, 4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), 1'b0,
               1'($urandom_range(0, 1)), PROTO_VERSION, SNAP_INTACT, 30);
    send_frame(FT_MGMT, SUB_BEACON, DS_NONE, 1'b0, 1'b0, PROTO_VERSION,
               SNAP_NONE, 34);
  endtask

  // Hold the receiver off for a long stretch while short frames pour in, so
  // the result register fills and the block stalls final bytes.
  task automatic test_result_backpressure();
    tx_gaps     = 1'b0;
    hold_cycles = HOLD_OFF;
    repeat (6) send_frame(FT_CTRL, SUB_ACK, DS_NONE, 1'b0, 1'b0, PROTO_VERSION,
                          SNAP_NONE, 0);
    tx_gaps = 1'b1;
  endtask

  // Mixed traffic, mostly well formed, until the byte budget is spent.
  // Idling on each side is switched per frame so some runs go back to back.
  task automatic test_random_traffic();
    frame_type_t ft;
    int          snap_kind;
    while (bytes_sent < ITEM_TARGET) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_gaps   = ($urandom_range(0, 3) != 0);
      ft        = frame_type_t'($urandom_range(0, 3));
      snap_kind = (ft == FT_DATA) ? $urandom_range(0, 2) : SNAP_NONE;
      send_random_frame(ft, snap_kind);
    end
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
  endtask

  initial begin
    rst        <= 1'b1;
    byte_valid <= 1'b0;
    data_byte  <= '0;
    last_byte  <= 1'b0;
    clear_shadow();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_short_frames();
    test_control_frames();
    test_management_frames();
    test_data_routing();
    test_eapol_detection();
    test_extension_frames();
    test_long_frames();
    test_result_backpressure();
    test_random_traffic();

    byte_valid <= 1'b0;
    // Wait for every outstanding result, then let the pipe settle.
    while (pending_headers.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending_headers.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/wmhp_pkg.sv
src/wmhp_decode.sv
src/wlan_mac_header_parser.sv
src/wmhp_checker.sv
bench/wlan_mac_header_parser_test.sv
